/* rtl/linear_recurrence_term_mod_assert.svh */
// assertion macros shared by the linear recurrence term block
`ifndef LINEAR_RECURRENCE_TERM_MOD_ASSERT_SVH
`define LINEAR_RECURRENCE_TERM_MOD_ASSERT_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define LRTM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define LRTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LRTM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LRTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/lrtm_pkg.sv */
// shared constants and types of the linear recurrence term block
`default_nettype none
package lrtm_pkg;
    localparam int VALUE_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF = 32;
    localparam int MODULUS_RESET  = 10000;
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;
    localparam logic [APB_ADDR_BITS-3:0] REG_MODULUS = '0;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;
endpackage
`default_nettype wire

/* rtl/lrtm_mulmod.sv */
// shared bit-serial unit: (x1*y1 + x2*y2) mod m, one bit of y per cycle
`default_nettype none
`include "linear_recurrence_term_mod_assert.svh"
module lrtm_mulmod import lrtm_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_m,
    input  wire logic [VALUE_BITS-1:0] i_x1,
    input  wire logic [VALUE_BITS-1:0] i_y1,
    input  wire logic [VALUE_BITS-1:0] i_x2,
    input  wire logic [VALUE_BITS-1:0] i_y2,
    output t_mm_status                 o_stat,
    output logic      [VALUE_BITS-1:0] o_result
);
    localparam int CW = $clog2(VALUE_BITS);
    localparam int SW = VALUE_BITS + 2;

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_bit;
    logic [VALUE_BITS-1:0] r_acc;
    logic [VALUE_BITS-1:0] r_m;
    logic [SW-1:0]         r_m2;
    logic [SW-1:0]         r_m3;
    logic [VALUE_BITS-1:0] r_x1;
    logic [VALUE_BITS-1:0] r_y1;
    logic [VALUE_BITS-1:0] r_x2;
    logic [VALUE_BITS-1:0] r_y2;

    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_m1;
    logic [SW-1:0] w_red;

    // sum stays below 4m since acc, x1, x2 are all residues
    assign w_m1  = {2'b00, r_m};
    assign w_sum = {1'b0, r_acc, 1'b0}
                 + (r_y1[r_bit] ? {2'b00, r_x1} : '0)
                 + (r_y2[r_bit] ? {2'b00, r_x2} : '0);

    always_comb begin
        priority if (w_sum >= r_m3) begin
            w_red = w_sum - r_m3;
        end else if (w_sum >= r_m2) begin
            w_red = w_sum - r_m2;
        end else if (w_sum >= w_m1) begin
            w_red = w_sum - w_m1;
        end else begin
            w_red = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_bit == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bit <= CW'(VALUE_BITS - 1);
            r_acc <= '0;
            r_m   <= i_m;
            r_m2  <= {1'b0, i_m, 1'b0};
            r_m3  <= {1'b0, i_m, 1'b0} + {2'b00, i_m};
            r_x1  <= i_x1;
            r_y1  <= i_y1;
            r_x2  <= i_x2;
            r_y2  <= i_y2;
        end else if (r_busy) begin
            r_acc <= w_red[VALUE_BITS-1:0];
            r_bit <= r_bit - 1'b1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_acc;

    `LRTM_ASSERT_NEXT(a_mm_finish, i_clk, i_rst_n, r_busy && (r_bit == '0) && !i_start, r_done && !r_busy)
    `LRTM_ASSERT_IMPL(a_mm_residue, i_clk, i_rst_n, r_done, r_acc < r_m)
    `LRTM_ASSERT_IMPL(a_mm_no_restart, i_clk, i_rst_n, i_start, !r_busy)
endmodule
`default_nettype wire

/* rtl/lrtm_regs.sv */
// configuration register file with the modulus register
`default_nettype none
module lrtm_regs import lrtm_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output logic      [VALUE_BITS-1:0]    o_modulus
);
    localparam logic [VALUE_BITS-1:0] MOD_RST = VALUE_BITS'(MODULUS_RESET);

    logic [VALUE_BITS-1:0] r_modulus;
    logic                  w_sel_mod;

    assign w_sel_mod = (paddr[APB_ADDR_BITS-1:2] == REG_MODULUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RST;
        end else if (psel && penable && pwrite && w_sel_mod) begin
            r_modulus <= pwdata[VALUE_BITS-1:0];
        end
    end

    assign prdata    = w_sel_mod ? APB_DATA_BITS'(r_modulus) : '0;
    assign pready    = 1'b1;
    assign o_modulus = r_modulus;
endmodule
`default_nettype wire

/* rtl/linear_recurrence_term_mod.sv */
// sequence: the four inputs are first reduced mod m, then per bit of k-1 a test state, a
// matrix accumulate when the bit is set and a matrix squaring, then a final product of the
// reduced seeds with the accumulated matrix gives the term
// throughput: one beat at a time, all set by the single bit-serial multiply-reduce unit
// k of zero skips the matrix loop, a modulus of zero goes straight to an answer of zero
// reset: synchronous active low, modulus returns to 10000, sequencer to idle
`default_nettype none
`include "linear_recurrence_term_mod_assert.svh"
module linear_recurrence_term_mod import lrtm_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [VALUE_BITS-1:0]    i_first_term,
    input  wire logic [VALUE_BITS-1:0]    i_second_term,
    input  wire logic [VALUE_BITS-1:0]    i_coeff_p,
    input  wire logic [VALUE_BITS-1:0]    i_coeff_q,
    input  wire logic [INDEX_BITS-1:0]    i_term_index,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic      [VALUE_BITS-1:0]    o_term_value
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RED  = 3'd1;
    localparam logic [2:0] ST_LOOP = 3'd2;
    localparam logic [2:0] ST_MACC = 3'd3;
    localparam logic [2:0] ST_SQR  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam logic [1:0] ENT_LAST = 2'd3;

    logic [2:0]            r_state;
    logic [1:0]            r_ent;
    logic                  r_issued;
    logic                  r_kz;
    logic [INDEX_BITS-1:0] r_e;
    // seeds and coefficients: a(0), a(1), p, q
    logic [VALUE_BITS-1:0] r_v0, r_v1, r_v2, r_v3;
    // accumulator and base matrices, row-major
    logic [VALUE_BITS-1:0] r_a00, r_a01, r_a10, r_a11;
    logic [VALUE_BITS-1:0] r_b00, r_b01, r_b10, r_b11;
    logic [VALUE_BITS-1:0] r_t0, r_t1, r_t2;
    logic [VALUE_BITS-1:0] r_res;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_val;

    logic [VALUE_BITS-1:0] w_modulus;
    logic [VALUE_BITS-1:0] w_one;
    logic                  w_active;
    logic                  w_start;
    logic                  w_handoff;
    logic [VALUE_BITS-1:0] w_x1, w_y1, w_x2, w_y2;
    logic [VALUE_BITS-1:0] w_res;
    logic [VALUE_BITS-1:0] w_l0, w_l1, w_l2, w_l3;
    t_mm_status            w_mm_stat;

    lrtm_regs #(
        .VALUE_BITS(VALUE_BITS)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_modulus(w_modulus)
    );

    lrtm_mulmod #(
        .VALUE_BITS(VALUE_BITS)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_m     (w_modulus),
        .i_x1    (w_x1),
        .i_y1    (w_y1),
        .i_x2    (w_x2),
        .i_y2    (w_y2),
        .o_stat  (w_mm_stat),
        .o_result(w_res)
    );

    assign w_one    = (w_modulus == VALUE_BITS'(1)) ? '0 : VALUE_BITS'(1);
    assign w_active = (r_state == ST_RED) || (r_state == ST_MACC)
                   || (r_state == ST_SQR) || (r_state == ST_FIN);
    assign w_start  = w_active && !r_issued;
    // finished term moves into the output register once it is free
    assign w_handoff = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    // left matrix is acc for the accumulate step, base for squaring
    assign w_l0 = (r_state == ST_SQR) ? r_b00 : r_a00;
    assign w_l1 = (r_state == ST_SQR) ? r_b01 : r_a01;
    assign w_l2 = (r_state == ST_SQR) ? r_b10 : r_a10;
    assign w_l3 = (r_state == ST_SQR) ? r_b11 : r_a11;

    always_comb begin
        w_x1 = '0;
        w_y1 = '0;
        w_x2 = '0;
        w_y2 = '0;
        unique case (r_state)
            ST_RED: begin
                // x mod m as 1 * x mod m
                w_x1 = w_one;
                unique case (r_ent)
                    2'd0: w_y1 = r_v0;
                    2'd1: w_y1 = r_v1;
                    2'd2: w_y1 = r_v2;
                    default: w_y1 = r_v3;
                endcase
            end
            ST_MACC, ST_SQR: begin
                unique case (r_ent)
                    2'd0: begin
                        w_x1 = w_l0; w_y1 = r_b00; w_x2 = w_l1; w_y2 = r_b10;
                    end
                    2'd1: begin
                        w_x1 = w_l0; w_y1 = r_b01; w_x2 = w_l1; w_y2 = r_b11;
                    end
                    2'd2: begin
                        w_x1 = w_l2; w_y1 = r_b00; w_x2 = w_l3; w_y2 = r_b10;
                    end
                    default: begin
                        w_x1 = w_l2; w_y1 = r_b01; w_x2 = w_l3; w_y2 = r_b11;
                    end
                endcase
            end
            ST_FIN: begin
                w_x1 = r_a00; w_y1 = r_v1; w_x2 = r_a01; w_y2 = r_v0;
            end
            default: begin
                w_x1 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ent       <= '0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_handoff) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_start) begin
                r_issued <= 1'b1;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_v0     <= i_first_term;
                        r_v1     <= i_second_term;
                        r_v2     <= i_coeff_p;
                        r_v3     <= i_coeff_q;
                        r_e      <= i_term_index - 1'b1;
                        r_kz     <= (i_term_index == '0);
                        r_ent    <= '0;
                        r_issued <= 1'b0;
                        if (w_modulus == '0) begin
                            r_res   <= '0;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_RED;
                        end
                    end
                end
                ST_RED: begin
                    if (w_mm_stat.done) begin
                        r_issued <= 1'b0;
                        unique case (r_ent)
                            2'd0: r_v0 <= w_res;
                            2'd1: r_v1 <= w_res;
                            2'd2: r_v2 <= w_res;
                            default: r_v3 <= w_res;
                        endcase
                        if (r_ent == ENT_LAST) begin
                            r_ent <= '0;
                            if (r_kz) begin
                                r_res   <= r_v0;
                                r_state <= ST_DONE;
                            end else begin
                                r_a00   <= w_one;
                                r_a01   <= '0;
                                r_a10   <= '0;
                                r_a11   <= w_one;
                                r_b00   <= r_v2;
                                r_b01   <= w_res;
                                r_b10   <= w_one;
                                r_b11   <= '0;
                                r_state <= ST_LOOP;
                            end
                        end else begin
                            r_ent <= r_ent + 1'b1;
                        end
                    end
                end
                ST_LOOP: begin
                    priority if (r_e == '0) begin
                        r_state <= ST_FIN;
                    end else if (r_e[0]) begin
                        r_state <= ST_MACC;
                    end else begin
                        r_state <= ST_SQR;
                    end
                end
                ST_MACC, ST_SQR: begin
                    if (w_mm_stat.done) begin
                        r_issued <= 1'b0;
                        unique case (r_ent)
                            2'd0: r_t0 <= w_res;
                            2'd1: r_t1 <= w_res;
                            2'd2: r_t2 <= w_res;
                            default: r_t2 <= r_t2;
                        endcase
                        if (r_ent == ENT_LAST) begin
                            r_ent <= '0;
                            if (r_state == ST_MACC) begin
                                r_a00   <= r_t0;
                                r_a01   <= r_t1;
                                r_a10   <= r_t2;
                                r_a11   <= w_res;
                                r_state <= ST_SQR;
                            end else begin
                                r_b00   <= r_t0;
                                r_b01   <= r_t1;
                                r_b10   <= r_t2;
                                r_b11   <= w_res;
                                r_e     <= r_e >> 1;
                                r_state <= ST_LOOP;
                            end
                        end else begin
                            r_ent <= r_ent + 1'b1;
                        end
                    end
                end
                ST_FIN: begin
                    if (w_mm_stat.done) begin
                        r_issued <= 1'b0;
                        r_res    <= w_res;
                        r_state  <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hand over once the output register is free
                    if (w_handoff) begin
                        r_out_val <= r_res;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_term_value = r_out_val;

    `LRTM_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state != ST_IDLE)
    `LRTM_ASSERT_IMPL(a_out_from_done, i_clk, i_rst_n, r_out_valid && !$past(r_out_valid), $past(r_state) == ST_DONE)
    `LRTM_ASSERT_IMPL(a_done_when_issued, i_clk, i_rst_n, w_mm_stat.done, r_issued && w_active)
endmodule
`default_nettype wire
